// ----- hw/rtl/icas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icas_pkg
// Shared types and constants of the image column additive synthesizer.
// ----------------------------------------------------------------------------
package icas_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_NORM  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [2:0] REG_BASE  = 3'd0;
  localparam logic [2:0] REG_RATIO = 3'd1;
  localparam logic [2:0] REG_GAIN  = 3'd2;
  localparam logic [2:0] REG_VOL   = 3'd3;
  localparam logic [2:0] REG_SPC   = 3'd4;
  localparam logic [2:0] REG_FADE  = 3'd5;
  localparam logic [2:0] REG_COLS  = 3'd6;
  localparam logic [2:0] REG_ROWS  = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  column;
    logic [5:0]  row;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [7:0]         current_column;
  } out_item_t;

  // front-to-back queue entry: a classified item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  column;
    logic [5:0]  row;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] base_increment;
    logic [31:0] row_ratio;
    logic [15:0] gain;
    logic [15:0] volume;
    logic [15:0] samples_per_column;
    logic [15:0] fade_length;
    logic [8:0]  columns_in_use;
    logic [6:0]  rows_in_use;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/image_column_additive_synth_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// image_column_additive_synth_top
// Additive sine bank sounding one image column at a time, cross-faded from the last.
// ----------------------------------------------------------------------------
// Store writes pass from the queue into the pixel or norm store, one per cycle
// while the engine is idle. A tick runs per row in use: store read, oscillator
// step, four sine steps, multiply, accumulate; then norm blend, scaling product
// and a 64-step divide before its result strobes. No new item is taken before
// that strobe, and a two-entry queue takes items meanwhile. Synchronous
// reset restores register defaults, phases and scan state; stores undefined.
module image_column_additive_synth_top #(
  parameter int MAX_COLUMNS     = 256,
  parameter int MAX_ROWS        = 64,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  icas_pkg::in_item_t        in_item,
  output logic                      out_strobe,
  output icas_pkg::out_item_t       out_item,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [4:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import icas_pkg::*;

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid, q_pop;

  icas_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  icas_front u_front (
    .clk, .rst_n, .start, .in_item, .busy, .q_cmd, .q_valid, .q_pop
  );

  icas_back #(
    .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk, .rst_n, .cfg, .q_cmd, .q_valid, .q_pop, .out_strobe, .out_item
  );
endmodule
`default_nettype wire

// ----- hw/rtl/icas_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icas_front
// Accepts items, drops unused kinds and queues the rest for the engine.
// ----------------------------------------------------------------------------
module icas_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  icas_pkg::in_item_t     in_item,
  output logic                   busy,
  output icas_pkg::cmd_t         q_cmd,
  output logic                   q_valid,
  input  wire logic              q_pop
);
  import icas_pkg::*;

  cmd_t       mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy && (in_item.kind != KIND_SPARE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) begin
      mem_r[wp_r] <= '{kind: in_item.kind, column: in_item.column,
                       row: in_item.row, value: in_item.value};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/icas_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icas_div
// Restoring divider, one quotient bit per cycle: floor(num/den).
// ----------------------------------------------------------------------------
module icas_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] num,
  input  wire logic [40:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic [6:0]  cnt_r;
  logic        run_r;
  logic [41:0] rem_r;
  logic [63:0] q_r;
  logic [41:0] trial;

  assign trial = {rem_r[40:0], q_r[63]} - {1'b0, den};
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 7'd0;
        rem_r <= '0;
        q_r   <= num;
      end else if (run_r) begin
        if (!trial[41]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[40:0], q_r[63]};
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/icas_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icas_back
// Executes queued items: store writes, and the per-row oscillator sweep,
// norm blend, scaling divide and column sequencing of a tick.
// ----------------------------------------------------------------------------
module icas_back #(
  parameter int MAX_COLUMNS     = 256,
  parameter int MAX_ROWS        = 64,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  icas_pkg::cfg_t     cfg,
  input  icas_pkg::cmd_t     q_cmd,
  input  wire logic          q_valid,
  output logic               q_pop,
  output logic               out_strobe,
  output icas_pkg::out_item_t out_item
);
  import icas_pkg::*;

  localparam int CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int QB = SINE_TABLE_BITS - 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ROW, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_MUL, S_ACC,
    S_NORM, S_SCALE, S_SUM, S_GO, S_DIVW
  } state_t;

  logic [7:0]  pix_mem [MAX_COLUMNS*MAX_ROWS];
  logic [15:0] norm_mem [MAX_COLUMNS];
  logic [31:0] phase_r [MAX_ROWS];
  // phases never stepped since reset read as zero
  logic [MAX_ROWS-1:0] ph_vld_r;

  state_t      state_r;
  logic [7:0]  col_now_r, col_bef_r;
  logic [15:0] sic_r, fpos_r;
  logic        fading_r;
  logic [RCW-1:0] row_r, nrows_r;
  logic [31:0] step_r;
  logic [16:0] wp_r, wc_r;
  logic        end_fade_r;
  logic [CB-1:0] cn_r, cb_r;
  logic [7:0]  pb_r, pn_r;
  logic [15:0] nb_r, nn_r;
  logic [31:0] ph_r;
  logic [16:0] u_r;
  logic [1:0]  quad_r;
  logic [16:0] x2_r;
  logic [16:0] t_r;
  logic [25:0] blend_r;
  logic signed [16:0] sin_r;
  logic signed [47:0] acc_r;
  logic signed [43:0] prod_r;
  logic [47:0] mag_r;
  logic [31:0] gv_r;
  logic [63:0] plo_r;
  logic [47:0] phi_r;
  logic        neg_r;
  logic        div_go;
  logic        div_done;
  logic [63:0] div_q;
  logic [63:0] num_r;
  logic [40:0] den_r;
  logic        sat_r;
  logic [63:0] step_mul;
  logic [RB-1:0] ridx;

  assign ridx = row_r[RB-1:0];
  assign step_mul = {32'd0, step_r} * {32'd0, cfg.row_ratio};

  icas_div u_div (
    .clk, .rst_n, .go(div_go), .num(num_r), .den(den_r),
    .done(div_done), .quo(div_q)
  );

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign div_go = (state_r == S_GO);

  logic [8:0] cols;
  always_comb begin
    cols = cfg.columns_in_use;
    if (cols > 9'(MAX_COLUMNS)) cols = 9'(MAX_COLUMNS);
    if (cols > 9'd256) cols = 9'd256;
  end

  always_ff @(posedge clk) begin
    logic [16:0] nxt;
    logic [63:0] lim;
    nxt = {1'b0, sic_r} + 17'd1;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      col_now_r  <= '0;
      col_bef_r  <= '0;
      sic_r      <= '0;
      fpos_r     <= '0;
      fading_r   <= 1'b0;
      out_strobe <= 1'b0;
      ph_vld_r   <= '0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_IDLE: if (q_valid) begin
          case (q_cmd.kind)
            KIND_PIXEL: if (32'(q_cmd.column) < MAX_COLUMNS && 32'(q_cmd.row) < MAX_ROWS)
              pix_mem[(CB+RB)'(q_cmd.column) * (CB+RB)'(MAX_ROWS) + (CB+RB)'(q_cmd.row)]
                <= (q_cmd.value > 16'd255) ? 8'd255 : q_cmd.value[7:0];
            KIND_NORM: if (32'(q_cmd.column) < MAX_COLUMNS)
              norm_mem[CB'(q_cmd.column)] <= q_cmd.value;
            KIND_TICK: begin
              cn_r <= (32'(col_now_r) < MAX_COLUMNS) ? CB'(col_now_r) : '0;
              cb_r <= (32'(col_bef_r) < MAX_COLUMNS) ? CB'(col_bef_r) : '0;
              if (fading_r && fpos_r < cfg.fade_length) begin
                wp_r <= {1'b0, cfg.fade_length - fpos_r};
                wc_r <= {1'b0, fpos_r};
                end_fade_r <= ({1'b0, fpos_r} + 17'd1) >= {1'b0, cfg.fade_length};
              end else begin
                wp_r <= '0;
                wc_r <= 17'd1;
                end_fade_r <= fading_r;
              end
              nrows_r <= (32'(cfg.rows_in_use) < MAX_ROWS) ? RCW'(cfg.rows_in_use)
                                                             : RCW'(MAX_ROWS);
              row_r  <= '0;
              step_r <= cfg.base_increment;
              acc_r  <= '0;
              state_r <= S_RD;
            end
            default: ;
          endcase
        end
        S_RD: begin
          if (row_r >= nrows_r) begin
            nb_r <= norm_mem[cb_r];
            nn_r <= norm_mem[cn_r];
            state_r <= S_NORM;
          end else begin
            pb_r <= pix_mem[(CB+RB)'(cb_r) * (CB+RB)'(MAX_ROWS) + (CB+RB)'(ridx)];
            pn_r <= pix_mem[(CB+RB)'(cn_r) * (CB+RB)'(MAX_ROWS) + (CB+RB)'(ridx)];
            ph_r <= ph_vld_r[ridx] ? phase_r[ridx] : '0;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          logic [31:0] ph_new;
          logic [SINE_TABLE_BITS-1:0] idx;
          logic [1:0]  quad;
          logic [16:0] uq;
          ph_new = ph_r + step_r;
          idx  = ph_new[31 -: SINE_TABLE_BITS];
          quad = idx[SINE_TABLE_BITS-1 -: 2];
          // position in the quarter wave, mirrored on odd quadrants
          uq   = 17'(idx[QB-1:0]) << (18 - SINE_TABLE_BITS);
          if (quad[0]) uq = 17'd65536 - uq;
          phase_r[ridx]  <= ph_new;
          ph_vld_r[ridx] <= 1'b1;
          u_r     <= uq;
          quad_r  <= quad;
          blend_r <= 26'({9'd0, pb_r} * wp_r + {9'd0, pn_r} * wc_r);
          step_r  <= (step_mul[63:30] > 34'hFFFFFFFF) ? 32'hFFFFFFFF : step_mul[61:30];
          state_r <= S_SIN1;
        end
        S_SIN1: begin
          x2_r    <= 17'(({17'd0, u_r} * {17'd0, u_r}) >> 16);
          state_r <= S_SIN2;
        end
        S_SIN2: begin
          t_r     <= 17'd42334 - 17'((34'd5223 * {17'd0, x2_r}) >> 16);
          state_r <= S_SIN3;
        end
        S_SIN3: begin
          t_r     <= 17'd102944 - 17'(({17'd0, x2_r} * {17'd0, t_r}) >> 16);
          state_r <= S_SIN4;
        end
        S_SIN4: begin
          logic [17:0] y;
          y = 18'(({17'd0, u_r} * {17'd0, t_r}) >> 16);
          if (y > 18'd65535) y = 18'd65535;
          sin_r   <= quad_r[1] ? -$signed({2'b0, y[15:1]}) : $signed({2'b0, y[15:1]});
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= $signed({1'b0, blend_r}) * sin_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + 48'(prod_r);
          row_r   <= row_r + RCW'(1);
          state_r <= S_RD;
        end
        S_NORM: begin
          logic [40:0] ns;
          ns = 41'({17'd0, nb_r} * wp_r + {17'd0, nn_r} * wc_r);
          if (ns == '0) ns = 41'(wp_r + wc_r);
          den_r  <= 41'(ns * 41'd255);
          neg_r  <= acc_r[47];
          mag_r  <= acc_r[47] ? 48'(-acc_r) : 48'(acc_r);
          gv_r   <= {16'd0, cfg.gain} * {16'd0, cfg.volume};
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          // magnitude below 2^45: split into a 32-bit and a 16-bit partial
          plo_r <= {32'd0, mag_r[31:0]} * {32'd0, gv_r};
          phi_r <= {32'd0, mag_r[47:32]} * {16'd0, gv_r};
          state_r <= S_SUM;
        end
        S_SUM: begin
          logic [79:0] full;
          full = {16'd0, plo_r} + {phi_r, 32'd0};
          num_r <= full[63:0];
          // any bit above 64 gives a quotient past full scale
          sat_r <= (full[79:64] != '0);
          state_r <= S_GO;
        end
        S_GO: state_r <= S_DIVW;
        S_DIVW: if (div_done) begin
          logic [63:0] q;
          lim = neg_r ? 64'd8388608 : 64'd8388607;
          q = (sat_r || div_q > lim) ? lim : div_q;
          out_item.sample <= neg_r ? 24'(-q) : q[23:0];
          if (fading_r) begin
            if (end_fade_r) begin
              fading_r <= 1'b0;
              fpos_r   <= '0;
            end else fpos_r <= fpos_r + 16'd1;
            out_item.current_column <= col_now_r;
          end else if (nxt >= {1'b0, cfg.samples_per_column}) begin
            sic_r     <= '0;
            col_bef_r <= col_now_r;
            col_now_r <= ({1'b0, col_now_r} + 9'd1 >= cols) ? 8'd0 : col_now_r + 8'd1;
            out_item.current_column <= ({1'b0, col_now_r} + 9'd1 >= cols) ? 8'd0
                                                                 : col_now_r + 8'd1;
            fading_r  <= 1'b1;
            fpos_r    <= '0;
          end else begin
            sic_r <= nxt[15:0];
            out_item.current_column <= col_now_r;
          end
          out_strobe <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/icas_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// icas_regs
// APB register file for the synthesizer settings.
// ----------------------------------------------------------------------------
module icas_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output icas_pkg::cfg_t   cfg
);
  import icas_pkg::*;

  logic [2:0] ri;
  assign ri = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg <= '{base_increment: 32'd97392, row_ratio: 32'd1107296256, gain: 16'd256,
               volume: 16'd256, samples_per_column: 16'd4410, fade_length: 16'd441,
               columns_in_use: 9'd256, rows_in_use: 7'd64};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ri)
        REG_BASE:  cfg.base_increment     <= cfg_pwdata;
        REG_RATIO: cfg.row_ratio          <= cfg_pwdata;
        REG_GAIN:  cfg.gain               <= cfg_pwdata[15:0];
        REG_VOL:   cfg.volume             <= cfg_pwdata[15:0];
        REG_SPC:   cfg.samples_per_column <= cfg_pwdata[15:0];
        REG_FADE:  cfg.fade_length        <= cfg_pwdata[15:0];
        REG_COLS:  cfg.columns_in_use     <= cfg_pwdata[8:0];
        REG_ROWS:  cfg.rows_in_use        <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ri)
      REG_BASE:  cfg_prdata = cfg.base_increment;
      REG_RATIO: cfg_prdata = cfg.row_ratio;
      REG_GAIN:  cfg_prdata = {16'd0, cfg.gain};
      REG_VOL:   cfg_prdata = {16'd0, cfg.volume};
      REG_SPC:   cfg_prdata = {16'd0, cfg.samples_per_column};
      REG_FADE:  cfg_prdata = {16'd0, cfg.fade_length};
      REG_COLS:  cfg_prdata = {23'd0, cfg.columns_in_use};
      REG_ROWS:  cfg_prdata = {25'd0, cfg.rows_in_use};
      default:   cfg_prdata = '0;
    endcase
  end
endmodule
`default_nettype wire
